>>> src/ile_pkg.sv
// Package for the indexed list engine: sizes, operation and status codes,
// cell control types shared by the cell row and the top level.
// No dependencies.
package ile_pkg;

	// list geometry
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// fixed field widths of the channels
	localparam int OP_W     = 3;
	localparam int INDEX_W  = 8;
	localparam int VALUE_W  = 32;
	localparam int LENGTH_W = 7;
	localparam int STATUS_W = 3;

	// compare width: holds an index plus one and the count
	localparam int CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
	localparam logic [OP_W-1:0] OP_SWAP   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ORDER  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BOUNDS = 3'd4;

	// per-cell next-value source
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_LEFT,
		CELL_RIGHT
	} cell_sel_t;

	// row-wide command
	typedef enum logic [1:0] {
		ROW_HOLD,
		ROW_INSERT,
		ROW_SHIFT_DOWN,
		ROW_SWAP
	} row_mode_t;

	typedef struct packed {
		row_mode_t mode;
		idx_t      pos_a;
		idx_t      pos_b;
		data_t     value;
	} row_cmd_t;

endpackage

>>> src/ile_req_if.sv
// Request channel of the indexed list engine: valid/ready plus operation fields.
// Depends on ile_pkg.
interface ile_req_if;
	import ile_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [INDEX_W-1:0]  index_a;
	logic [INDEX_W-1:0]  index_b;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output op, output index_a, output index_b,
		output value, input ready);
	modport sink (input valid, input op, input index_a, input index_b,
		input value, output ready);
endinterface

>>> src/ile_rsp_if.sv
// Response channel of the indexed list engine: valid/ready plus result fields.
// Depends on ile_pkg.
interface ile_rsp_if;
	import ile_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  read_value;
	logic [LENGTH_W-1:0] length;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output read_value, output length,
		output status, input ready);
	modport sink (input valid, input read_value, input length,
		input status, output ready);
endinterface

>>> src/ile_cell.sv
// One list cell: a data word that holds, loads, or takes a neighbor's word.
// Depends on ile_pkg.
module ile_cell (
	input  logic              clk,
	input  ile_pkg::cell_sel_t sel,
	input  ile_pkg::data_t     load_data,
	input  ile_pkg::data_t     left_data,
	input  ile_pkg::data_t     right_data,
	output ile_pkg::data_t     data
);
	import ile_pkg::*;

	data_t data_q;

	// next word from own source select
	always_ff @(posedge clk) begin
		case (sel)
			CELL_LOAD:  data_q <= load_data;
			CELL_LEFT:  data_q <= left_data;
			CELL_RIGHT: data_q <= right_data;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;
endmodule

>>> src/ile_row.sv
// Row of CAPACITY cells with per-cell decode of the row command and two
// read ports. Depends on ile_pkg and ile_cell.
module ile_row (
	input  logic              clk,
	input  ile_pkg::row_cmd_t cmd,
	output ile_pkg::data_t    rd_a
);
	import ile_pkg::*;

	data_t cell_data [CAPACITY];
	data_t rd_b;

	// read ports at the command positions
	assign rd_a = cell_data[cmd.pos_a];
	assign rd_b = cell_data[cmd.pos_b];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_sel_t sel;
		data_t     load_data;
		data_t     left_data;
		data_t     right_data;
		idx_t      my_idx;

		assign my_idx     = IDX_W'(i);
		assign left_data  = (i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i - 1];
		assign right_data = (i == CAPACITY - 1) ? cell_data[i]
			: cell_data[(i == CAPACITY - 1) ? i : i + 1];

		// per-cell decode
		always_comb begin
			sel       = CELL_HOLD;
			load_data = cmd.value;
			case (cmd.mode)
				ROW_INSERT: begin
					if (my_idx == cmd.pos_a) begin
						sel = CELL_LOAD;
					end else if (my_idx > cmd.pos_a) begin
						sel = CELL_LEFT;
					end
				end
				ROW_SHIFT_DOWN: begin
					if (my_idx >= cmd.pos_a) begin
						sel = CELL_RIGHT;
					end
				end
				ROW_SWAP: begin
					if (my_idx == cmd.pos_a) begin
						sel       = CELL_LOAD;
						load_data = rd_b;
					end else if (my_idx == cmd.pos_b) begin
						sel       = CELL_LOAD;
						load_data = rd_a;
					end
				end
				default: sel = CELL_HOLD;
			endcase
		end

		ile_cell u_cell (
			.clk        (clk),
			.sel        (sel),
			.load_data  (load_data),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i])
		);
	end
endmodule

>>> src/indexed_list_engine_core.sv
// Indexed list engine. Every operation but an erase that leaves entries behind
// its range registers its result at the request transfer, and the next request
// can be taken with the result transfer. Such an erase of n entries shifts the
// cell row down one place a cycle, then registers its result once the response
// register is free; no request is taken until then.
// Reset (arst_n low, asynchronous) empties the list; cell words are not reset.
module indexed_list_engine_core (
	input  logic         clk,
	input  logic         arst_n,
	ile_req_if.sink      req,
	ile_rsp_if.source    rsp
);
	import ile_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_ERASE
	} state_t;

	state_t                state_q;
	cnt_t                  count_q;
	idx_t                  erase_pos_q;
	cnt_t                  erase_left_q;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_read_value_q;
	logic [LENGTH_W-1:0]   out_length_q;
	logic [STATUS_W-1:0]   out_status_q;

	row_cmd_t              cmd;
	data_t                 rd_a;

	logic                  out_free;
	logic                  accept;
	logic [CMP_W-1:0]      cnt_w;
	logic [CMP_W-1:0]      ia_w;
	logic [CMP_W-1:0]      ib_w;
	logic [CMP_W-1:0]      last_raw;
	logic [CMP_W-1:0]      last_w;
	logic [STATUS_W-1:0]   new_status;
	cnt_t                  new_count;
	logic                  new_rd_en;
	logic                  go_erase;
	cnt_t                  erase_n;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign cnt_w    = CMP_W'(count_q);
	assign ia_w     = CMP_W'(req.index_a);
	assign ib_w     = CMP_W'(req.index_b);
	assign last_raw = (req.index_a == req.index_b) ? ia_w + CMP_W'(1) : ib_w;
	assign last_w   = (last_raw > cnt_w) ? cnt_w : last_raw;
	assign erase_n  = CNT_W'(last_w - ia_w);

	// operation decode, row command and result
	always_comb begin
		cmd.mode   = ROW_HOLD;
		cmd.pos_a  = IDX_W'(req.index_a);
		cmd.pos_b  = IDX_W'(req.index_b);
		cmd.value  = DATA_WIDTH'(req.value);
		new_status = ST_OK;
		new_count  = count_q;
		new_rd_en  = 1'b0;
		go_erase   = 1'b0;
		if (state_q == S_ERASE) begin
			cmd.pos_a = erase_pos_q;
			if (erase_left_q != '0) begin
				cmd.mode = ROW_SHIFT_DOWN;
			end
		end else if (accept) begin
			case (req.op)
				OP_INSERT: begin
					if (count_q == CNT_W'(CAPACITY)) begin
						new_status = ST_FULL;
					end else begin
						cmd.mode  = ROW_INSERT;
						cmd.pos_a = (ia_w > cnt_w) ? IDX_W'(count_q) : IDX_W'(req.index_a);
						new_count = count_q + CNT_W'(1);
					end
				end
				OP_READ: begin
					if (count_q == '0) begin
						new_status = ST_EMPTY;
					end else begin
						new_rd_en = 1'b1;
						cmd.pos_a = (ia_w >= cnt_w) ? IDX_W'(count_q - CNT_W'(1))
							: IDX_W'(req.index_a);
					end
				end
				OP_ERASE: begin
					if (count_q == '0) begin
						new_status = ST_EMPTY;
					end else if (req.index_a > req.index_b) begin
						new_status = ST_ORDER;
					end else if (ia_w >= cnt_w) begin
						new_status = ST_BOUNDS;
					end else if (last_w == cnt_w) begin
						// range reaches the tail: just cut the length
						new_count = CNT_W'(req.index_a);
					end else begin
						go_erase = 1'b1;
					end
				end
				OP_SWAP: begin
					if (count_q == '0) begin
						new_status = ST_EMPTY;
					end else if (ia_w >= cnt_w || ib_w >= cnt_w) begin
						new_status = ST_BOUNDS;
					end else begin
						cmd.mode = ROW_SWAP;
					end
				end
				OP_CLEAR: new_count = '0;
				default:  new_status = ST_OK;
			endcase
		end
	end

	ile_row u_row (
		.clk  (clk),
		.cmd  (cmd),
		.rd_a (rd_a)
	);

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			count_q          <= '0;
			erase_pos_q      <= '0;
			erase_left_q     <= '0;
			out_valid_q      <= 1'b0;
			out_read_value_q <= '0;
			out_length_q     <= '0;
			out_status_q     <= ST_OK;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && go_erase) begin
						state_q      <= S_ERASE;
						erase_pos_q  <= IDX_W'(req.index_a);
						erase_left_q <= erase_n;
					end else if (accept) begin
						count_q          <= new_count;
						out_valid_q      <= 1'b1;
						out_read_value_q <= new_rd_en ? VALUE_W'(rd_a) : '0;
						out_length_q     <= LENGTH_W'(new_count);
						out_status_q     <= new_status;
					end
				end
				S_ERASE: begin
					if (erase_left_q != '0) begin
						count_q      <= count_q - CNT_W'(1);
						erase_left_q <= erase_left_q - CNT_W'(1);
					end else if (out_free) begin
						state_q          <= S_IDLE;
						out_valid_q      <= 1'b1;
						out_read_value_q <= '0;
						out_length_q     <= LENGTH_W'(count_q);
						out_status_q     <= ST_OK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_read_value_q;
	assign rsp.length     = out_length_q;
	assign rsp.status     = out_status_q;
endmodule
